>>> hw/rtl/waveform_peak_rms_decimator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the waveform peak/RMS decimator
// Concurrent assertion wrappers with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_PEAK_RMS_DECIMATOR_ASSERT_SVH
`define WAVEFORM_PEAK_RMS_DECIMATOR_ASSERT_SVH

// check prop at every rising clock edge outside reset
`define WPR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("wpr assertion failed");

// check prop at every rising clock edge, reset included
`define WPR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("wpr assertion failed");

`endif

>>> hw/rtl/wpr_pkg.sv
// ----------------------------------------------------------------------------
// wpr_pkg
// Shared constants and register codes of the waveform peak/RMS decimator.
// ----------------------------------------------------------------------------
package wpr_pkg;

   localparam int MAX_CHANNELS_DEF = 8;
   localparam int SAMPLE_BITS_DEF  = 16;

   localparam int COUNT_BITS     = 16;
   localparam int PIXEL_BITS     = 16;
   localparam int CHANNEL_BITS   = 3;
   localparam int SPP_BITS       = 16;
   localparam int CC_BITS        = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [SPP_BITS-1:0] SPP_RESET = 16'd512;
   localparam logic [CC_BITS-1:0]  CC_RESET  = 4'd2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SAMPLES_PER_PIXEL = 2'd0,
      CSR_CHANNEL_COUNT     = 2'd1
   } csr_index_type;

endpackage

>>> hw/rtl/wpr_req_if.sv
// ----------------------------------------------------------------------------
// wpr_req_if
// Sample request channel: valid/ready with sample and framing flags.
// ----------------------------------------------------------------------------
interface wpr_req_if #(
   parameter int SAMPLE_BITS = wpr_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          buffer_start;
   logic                          channel_final;

   modport source (output valid, output sample, output buffer_start,
                   output channel_final, input ready);
   modport sink   (input valid, input sample, input buffer_start,
                   input channel_final, output ready);
endinterface

>>> hw/rtl/wpr_rsp_if.sv
// ----------------------------------------------------------------------------
// wpr_rsp_if
// Pixel response channel: valid/ready with one finished pixel.
// ----------------------------------------------------------------------------
interface wpr_rsp_if #(
   parameter int SAMPLE_BITS = wpr_pkg::SAMPLE_BITS_DEF
);
   logic                               valid;
   logic                               ready;
   logic [wpr_pkg::CHANNEL_BITS-1:0]   channel;
   logic [wpr_pkg::PIXEL_BITS-1:0]     pixel_index;
   logic signed [SAMPLE_BITS-1:0]      peak_high;
   logic signed [SAMPLE_BITS-1:0]      peak_low;
   logic [SAMPLE_BITS-1:0]             rms;
   logic [wpr_pkg::COUNT_BITS-1:0]     sample_total;

   modport source (output valid, output channel, output pixel_index, output peak_high,
                   output peak_low, output rms, output sample_total, input ready);
   modport sink   (input valid, input channel, input pixel_index, input peak_high,
                   input peak_low, input rms, input sample_total, output ready);
endinterface

>>> hw/rtl/wpr_chan_ram.sv
// ----------------------------------------------------------------------------
// wpr_chan_ram
// Per-channel accumulator store, one write and one registered read port.
// ----------------------------------------------------------------------------
module wpr_chan_ram #(
   parameter int DEPTH  = wpr_pkg::MAX_CHANNELS_DEF,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 3
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/wpr_rms_unit.sv
// ----------------------------------------------------------------------------
// wpr_rms_unit
// Iterative mean and root: restoring divide, then digit-by-digit square root.
// ----------------------------------------------------------------------------
module wpr_rms_unit #(
   parameter int SAMPLE_BITS = wpr_pkg::SAMPLE_BITS_DEF,
   parameter int SUM_W       = 2 * wpr_pkg::SAMPLE_BITS_DEF - 2 + wpr_pkg::COUNT_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [SUM_W-1:0]               sum,
   input  logic [wpr_pkg::COUNT_BITS-1:0] count,
   output logic                           done,
   output logic [SAMPLE_BITS-1:0]         rms
);
   localparam int CW  = wpr_pkg::COUNT_BITS;
   localparam int RW  = 2 * SAMPLE_BITS;
   localparam int SRW = SAMPLE_BITS + 2;
   localparam int IW  = $clog2(SUM_W + 1);

   typedef enum logic [1:0] {PH_IDLE, PH_DIV, PH_SQRT} phase_type;

   phase_type              phase_ff;
   logic [IW-1:0]          step_ff;
   logic [SUM_W-1:0]       num_ff;
   logic [CW-1:0]          den_ff;
   logic [CW-1:0]          rem_ff;
   logic [RW-1:0]          rad_ff;
   logic [SRW-1:0]         srem_ff;
   logic [SAMPLE_BITS-1:0] root_ff;
   logic                   done_ff;

   logic [CW:0]            rem_sh;
   logic                   div_ge;
   logic [CW:0]            rem_in;
   logic [SRW+1:0]         srem_sh;
   logic [SRW+1:0]         trial;
   logic                   sq_ge;
   logic [SRW+1:0]         srem_diff;

   always_comb begin
      rem_sh    = {rem_ff, num_ff[SUM_W-1]};
      div_ge    = rem_sh >= {1'b0, den_ff};
      rem_in    = div_ge ? rem_sh - {1'b0, den_ff} : rem_sh;
      srem_sh   = {srem_ff, rad_ff[RW-1:RW-2]};
      trial     = (SRW+2)'({root_ff, 2'b01});
      sq_ge     = srem_sh >= trial;
      srem_diff = sq_ge ? srem_sh - trial : srem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (phase_ff)
            PH_IDLE: begin
               if (start) begin
                  phase_ff <= PH_DIV;
                  step_ff  <= IW'(SUM_W - 1);
                  num_ff   <= sum;
                  den_ff   <= count;
                  rem_ff   <= '0;
               end
            end
            PH_DIV: begin
               rem_ff <= rem_in[CW-1:0];
               num_ff <= {num_ff[SUM_W-2:0], div_ge};
               if (step_ff == '0) begin
                  phase_ff <= PH_SQRT;
                  step_ff  <= IW'(SAMPLE_BITS - 1);
                  rad_ff   <= RW'({num_ff[SUM_W-2:0], div_ge});
                  srem_ff  <= '0;
                  root_ff  <= '0;
               end else begin
                  step_ff <= step_ff - 1'b1;
               end
            end
            PH_SQRT: begin
               srem_ff <= srem_diff[SRW-1:0];
               root_ff <= {root_ff[SAMPLE_BITS-2:0], sq_ge};
               rad_ff  <= {rad_ff[RW-3:0], 2'b00};
               if (step_ff == '0) begin
                  phase_ff <= PH_IDLE;
                  done_ff  <= 1'b1;
               end else begin
                  step_ff <= step_ff - 1'b1;
               end
            end
            default: phase_ff <= PH_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign rms  = root_ff;
endmodule

>>> hw/rtl/waveform_peak_rms_decimator.sv
// ----------------------------------------------------------------------------
// waveform_peak_rms_decimator
// Per-channel peak-high, peak-low and RMS decimation of interleaved samples.
//
//   channel   direction  handshake       payload
//   req_bus   in         valid/ready     sample, buffer_start, channel_final
//   rsp_bus   out        valid/ready     channel, pixel_index, peaks, rms, total
//   csr_*     in         write enable    index, 16-bit data
//
// A sample that closes no pixel passes accept, store read and update.
// A closing sample adds the RMS unit: SUM_W divide steps plus SAMPLE_BITS
// root steps, then a flush into the response registers.
// Synchronous reset; the store needs no clearing pass (per-entry valid bits).
// A stalled response holds; the next sample is taken while it waits.
// ----------------------------------------------------------------------------
module waveform_peak_rms_decimator #(
   parameter int MAX_CHANNELS = wpr_pkg::MAX_CHANNELS_DEF,
   parameter int SAMPLE_BITS  = wpr_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   wpr_req_if.sink                           req_bus,
   wpr_rsp_if.source                         rsp_bus,
   input  logic                              csr_write_enable,
   input  logic [wpr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wpr_pkg::CSR_DATA_BITS-1:0] csr_write_data
);
   localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CC_W  = ($clog2(MAX_CHANNELS + 1) > wpr_pkg::CC_BITS) ?
                          $clog2(MAX_CHANNELS + 1) : wpr_pkg::CC_BITS;
   localparam int SB    = SAMPLE_BITS;
   localparam int CNT_W = wpr_pkg::COUNT_BITS;
   localparam int PIX_W = wpr_pkg::PIXEL_BITS;
   localparam int SUM_W = 2 * SB - 2 + CNT_W;
   localparam int ENT_W = 2 * SB + SUM_W + CNT_W + PIX_W;

   localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
   localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};

   typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_UPDATE, ST_CALC, ST_FLUSH} state_type;

   state_type                   state_ff;
   logic [wpr_pkg::SPP_BITS-1:0] spp_ff;
   logic [wpr_pkg::CC_BITS-1:0] cc_ff;
   logic [CH_W-1:0]             ptr_ff;
   logic [MAX_CHANNELS-1:0]     valid_ff;

   logic [CH_W-1:0]             ch_ff;
   logic signed [SB-1:0]        samp_ff;
   logic [2*SB-1:0]             sq_ff;
   logic                        final_ff;
   logic                        hit_ff;

   logic [wpr_pkg::CHANNEL_BITS-1:0] res_ch_ff;
   logic [PIX_W-1:0]            res_pix_ff;
   logic signed [SB-1:0]        res_high_ff;
   logic signed [SB-1:0]        res_low_ff;
   logic [CNT_W-1:0]            res_cnt_ff;

   logic                        rsp_valid_ff;
   logic [wpr_pkg::CHANNEL_BITS-1:0] rsp_ch_ff;
   logic [PIX_W-1:0]            rsp_pix_ff;
   logic signed [SB-1:0]        rsp_high_ff;
   logic signed [SB-1:0]        rsp_low_ff;
   logic [SB-1:0]               rsp_rms_ff;
   logic [CNT_W-1:0]            rsp_cnt_ff;

   logic                        accept;
   logic [CC_W-1:0]             cc_eff;
   logic [CH_W-1:0]             ptr_base;
   logic [CH_W-1:0]             ch_sel;
   logic [CH_W-1:0]             ptr_in;
   logic [SB-1:0]               mag;
   logic [CNT_W-1:0]            spp_eff;

   logic [ENT_W-1:0]            rd_data;
   logic [ENT_W-1:0]            ent;
   logic signed [SB-1:0]        ent_high;
   logic signed [SB-1:0]        ent_low;
   logic [SUM_W-1:0]            ent_sum;
   logic [CNT_W-1:0]            ent_cnt;
   logic [PIX_W-1:0]            ent_pix;
   logic signed [SB-1:0]        new_high;
   logic signed [SB-1:0]        new_low;
   logic [SUM_W-1:0]            new_sum;
   logic [CNT_W-1:0]            new_cnt;
   logic                        emit;
   logic [ENT_W-1:0]            wr_data;
   logic                        wr_en;
   logic                        rms_start;
   logic                        rms_done;
   logic [SB-1:0]               rms_value;
   logic                        out_free;

   assign accept  = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      cc_eff = CC_W'(cc_ff);
      if (cc_eff == '0) begin
         cc_eff = CC_W'(1);
      end else if (cc_eff > CC_W'(MAX_CHANNELS)) begin
         cc_eff = CC_W'(MAX_CHANNELS);
      end
      ptr_base = req_bus.buffer_start ? '0 : ptr_ff;
      ch_sel   = (CC_W'(ptr_base) >= cc_eff) ? '0 : ptr_base;
      ptr_in   = ((CC_W'(ch_sel) + CC_W'(1)) >= cc_eff) ? '0 : CH_W'(ch_sel + 1'b1);
      mag      = req_bus.sample[SB-1] ? SB'(~req_bus.sample + 1'b1) : SB'(req_bus.sample);
      spp_eff  = (spp_ff == '0) ? CNT_W'(1) : spp_ff;
   end

   always_comb begin
      ent      = hit_ff ? rd_data : {PIX_W'(0), CNT_W'(0), SUM_W'(0), S_MAX, S_MIN};
      ent_high = ent[SB-1:0];
      ent_low  = ent[2*SB-1:SB];
      ent_sum  = ent[2*SB+SUM_W-1:2*SB];
      ent_cnt  = ent[2*SB+SUM_W+CNT_W-1:2*SB+SUM_W];
      ent_pix  = ent[ENT_W-1:ENT_W-PIX_W];
      new_high = (samp_ff > ent_high) ? samp_ff : ent_high;
      new_low  = (samp_ff < ent_low) ? samp_ff : ent_low;
      new_sum  = ent_sum + SUM_W'(sq_ff);
      new_cnt  = ent_cnt + 1'b1;
      emit     = (new_cnt >= spp_eff) || final_ff;
      wr_data  = emit ? {PIX_W'(ent_pix + 1'b1), CNT_W'(0), SUM_W'(0), S_MAX, S_MIN}
                      : {ent_pix, new_cnt, new_sum, new_low, new_high};
      wr_en     = (state_ff == ST_UPDATE);
      rms_start = (state_ff == ST_UPDATE) && emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spp_ff <= wpr_pkg::SPP_RESET;
         cc_ff  <= wpr_pkg::CC_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            wpr_pkg::CSR_SAMPLES_PER_PIXEL: spp_ff <= csr_write_data;
            wpr_pkg::CSR_CHANNEL_COUNT:     cc_ff  <= csr_write_data[wpr_pkg::CC_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_FLUSH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_READ;
                  ptr_ff   <= ptr_in;
                  ch_ff    <= ch_sel;
                  samp_ff  <= req_bus.sample;
                  sq_ff    <= mag * mag;
                  final_ff <= req_bus.channel_final;
                  hit_ff   <= !req_bus.buffer_start && valid_ff[ch_sel];
                  if (req_bus.buffer_start) begin
                     valid_ff <= '0;
                  end
               end
            end
            ST_READ: begin
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               valid_ff[ch_ff] <= 1'b1;
               res_ch_ff   <= wpr_pkg::CHANNEL_BITS'(ch_ff);
               res_pix_ff  <= ent_pix;
               res_high_ff <= new_high;
               res_low_ff  <= new_low;
               res_cnt_ff  <= new_cnt;
               state_ff    <= emit ? ST_CALC : ST_IDLE;
            end
            ST_CALC: begin
               if (rms_done) begin
                  state_ff <= ST_FLUSH;
               end
            end
            ST_FLUSH: begin
               if (out_free) begin
                  rsp_ch_ff    <= res_ch_ff;
                  rsp_pix_ff   <= res_pix_ff;
                  rsp_high_ff  <= res_high_ff;
                  rsp_low_ff   <= res_low_ff;
                  rsp_rms_ff   <= rms_value;
                  rsp_cnt_ff   <= res_cnt_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   wpr_chan_ram #(
      .DEPTH  (MAX_CHANNELS),
      .WIDTH  (ENT_W),
      .ADDR_W (CH_W)
   ) u_chan_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ch_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (ch_sel),
      .rd_data (rd_data)
   );

   wpr_rms_unit #(
      .SAMPLE_BITS (SB),
      .SUM_W       (SUM_W)
   ) u_rms_unit (
      .clock (clock),
      .reset (reset),
      .start (rms_start),
      .sum   (new_sum),
      .count (new_cnt),
      .done  (rms_done),
      .rms   (rms_value)
   );

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.channel      = rsp_ch_ff;
   assign rsp_bus.pixel_index  = rsp_pix_ff;
   assign rsp_bus.peak_high    = rsp_high_ff;
   assign rsp_bus.peak_low     = rsp_low_ff;
   assign rsp_bus.rms          = rsp_rms_ff;
   assign rsp_bus.sample_total = rsp_cnt_ff;
endmodule

>>> hw/rtl/wpr_checker.sv
// ----------------------------------------------------------------------------
// wpr_checker
// Port-level checks of the decimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "waveform_peak_rms_decimator_assert.svh"

module wpr_checker #(
   parameter int SAMPLE_BITS = wpr_pkg::SAMPLE_BITS_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [SAMPLE_BITS-1:0]  rsp_peak_high,
   input logic signed [SAMPLE_BITS-1:0]  rsp_peak_low,
   input logic [SAMPLE_BITS-1:0]         rsp_rms,
   input logic [wpr_pkg::COUNT_BITS-1:0] rsp_sample_total
);
   localparam logic [SAMPLE_BITS-1:0] RMS_TOP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   `WPR_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid)
   `WPR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `WPR_ASSERT(a_peak_order, clock, reset, rsp_valid |-> rsp_peak_low <= rsp_peak_high)
   `WPR_ASSERT(a_total_rms, clock, reset, rsp_valid |-> rsp_sample_total != 0 && rsp_rms <= RMS_TOP)
endmodule

bind waveform_peak_rms_decimator wpr_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_wpr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_peak_high    (rsp_bus.peak_high),
   .rsp_peak_low     (rsp_bus.peak_low),
   .rsp_rms          (rsp_bus.rms),
   .rsp_sample_total (rsp_bus.sample_total)
);
